>>> hw/rtl/sowl_pkg.sv
// ----------------------------------------------------------------------------
// sowl_pkg
// Shared types and constants for the shell operator word lexer: token kinds,
// held operator codes, operator characters and the token queue push bundle.
// ----------------------------------------------------------------------------
package sowl_pkg;

	localparam int MAX_LINE   = 1024;
	localparam int POS_W      = $clog2(MAX_LINE) + 1;
	localparam int BEG_W      = $clog2(MAX_LINE);
	localparam int RANK_W     = 16;
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH) + 1;

	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;

	typedef enum logic [2:0] {
		KIND_WORD     = 3'd0,
		KIND_IN_REDIR = 3'd1,
		KIND_OUT_REDIR= 3'd2,
		KIND_PIPE     = 3'd3,
		KIND_HEREDOC  = 3'd4,
		KIND_APPEND   = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		HELD_NONE = 2'd0,
		HELD_LT   = 2'd1,
		HELD_GT   = 2'd2
	} held_t;

	typedef struct packed {
		kind_t             kind;
		logic [BEG_W-1:0]  start;
		logic [POS_W-1:0]  stop;
		logic              last;
	} token_t;

	typedef struct packed {
		logic [1:0] cnt;
		token_t     tok0;
		token_t     tok1;
	} push_t;

endpackage

>>> hw/rtl/sowl_tok_fifo.sv
// ----------------------------------------------------------------------------
// sowl_tok_fifo
// Small token queue: takes up to two tokens a cycle while room is high, hands
// out one a cycle on a valid/stall output channel while out_stall is low.
// ----------------------------------------------------------------------------
module sowl_tok_fifo import sowl_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  push_t  push,
	output logic   room,
	output logic   out_valid,
	input  logic   out_stall,
	output token_t out_tok
);

	token_t           mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;
	logic [PTR_W-1:0] wr_ptr_nx;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && !out_stall;
	assign out_tok   = mem_q[rd_ptr_q];
	assign room      = (count_q <= CNT_W'(FIFO_DEPTH - 2));
	assign wr_ptr_nx = wr_ptr_q + PTR_W'(1);

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= push.tok0;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wr_ptr_nx] <= push.tok1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push.cnt) - CNT_W'(pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(FIFO_DEPTH))
		else $error("token queue count exceeds depth");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt != 2'd0) |-> room)
		else $error("token push without room");

	a_push_last: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt == 2'd2) |-> (push.tok1.last && !push.tok0.last))
		else $error("run end flag misplaced on double push");

endmodule

>>> hw/rtl/shell_operator_word_lexer_core.sv
// ----------------------------------------------------------------------------
// shell_operator_word_lexer_core
// Command-line tokenizer: one byte per beat, cut at | < > and end of line,
// quotes hide operators, << and >> pair up. Emits kind/start/end/rank.
//
//   channel   signals                      direction  beat when
//   input     in_valid/in_stall + fields   in         in_valid & !in_stall
//   output    out_valid/out_stall + fields out        out_valid & !out_stall
//   config    cfg_valid/cfg_ready, rank    in         cfg_valid & cfg_ready
//
// One byte per cycle while in_stall is low: input register, one pass of logic, token queue.
// A byte yields zero to two tokens; the queue drains one token per cycle
// while out_stall is low, so two-token bytes cost extra output bandwidth.
// Reset clears line state and rank; the terminator clears line state.
// in_stall rises only while the input register holds a byte and the
// queue cannot take two more tokens.
// ----------------------------------------------------------------------------
module shell_operator_word_lexer_core import sowl_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          char_byte,
	input  logic                is_terminator,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [2:0]          token_kind,
	output logic [BEG_W-1:0]    token_start,
	output logic [POS_W-1:0]    token_end,
	output logic [RANK_W-1:0]   token_rank,
	output logic                last_of_run,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [RANK_W-1:0]   line_rank
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              term_s1;
	logic [RANK_W-1:0] rank_q;

	logic [POS_W-1:0] pos_q,  n_pos;
	logic             wo_q,   n_wo;
	logic [BEG_W-1:0] wb_q,   n_wb;
	logic             inq_q,  n_inq;
	logic             qd_q,   n_qd;
	held_t            held_q, n_held;
	logic [BEG_W-1:0] hp_q,   n_hp;

	logic   room;
	logic   step;
	logic   accept;
	push_t  push;
	token_t out_tok;

	assign step      = valid_s1 && room;
	assign in_stall  = valid_s1 && !room;
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= char_byte;
			term_s1 <= is_terminator;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			rank_q   <= '0;
			pos_q    <= '0;
			wo_q     <= 1'b0;
			wb_q     <= '0;
			inq_q    <= 1'b0;
			qd_q     <= 1'b0;
			held_q   <= HELD_NONE;
			hp_q     <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (step) begin
				valid_s1 <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				rank_q <= line_rank;
			end
			if (step) begin
				pos_q  <= n_pos;
				wo_q   <= n_wo;
				wb_q   <= n_wb;
				inq_q  <= n_inq;
				qd_q   <= n_qd;
				held_q <= n_held;
				hp_q   <= n_hp;
			end
		end
	end

	always_comb begin
		logic             is_quote;
		logic             is_op;
		logic [BEG_W-1:0] p;
		logic [7:0]       twin;
		kind_t            hk;
		kind_t            pk;
		logic             run_take;
		logic             va, vb, vc;
		token_t           ta, tb, tc;
		logic [1:0]       n;

		n_pos  = pos_q;
		n_wo   = wo_q;
		n_wb   = wb_q;
		n_inq  = inq_q;
		n_qd   = qd_q;
		n_held = held_q;
		n_hp   = hp_q;
		p        = pos_q[BEG_W-1:0];
		is_quote = (byte_s1 == CH_SQUOTE) || (byte_s1 == CH_DQUOTE);
		is_op    = (byte_s1 == CH_PIPE) || (byte_s1 == CH_LT) || (byte_s1 == CH_GT);
		run_take = 1'b0;
		va = 1'b0;
		vb = 1'b0;
		vc = 1'b0;
		ta = '0;
		tb = '0;
		tc = '0;

		case (held_q)
			HELD_LT: begin
				hk   = KIND_IN_REDIR;
				pk   = KIND_HEREDOC;
				twin = CH_LT;
			end
			default: begin
				hk   = KIND_OUT_REDIR;
				pk   = KIND_APPEND;
				twin = CH_GT;
			end
		endcase

		if (term_s1) begin
			if (held_q != HELD_NONE) begin
				va       = 1'b1;
				ta.kind  = hk;
				ta.start = hp_q;
				ta.stop  = {1'b0, hp_q} + POS_W'(1);
			end
			if (wo_q && !inq_q) begin
				vb       = 1'b1;
				tb.kind  = KIND_WORD;
				tb.start = wb_q;
				tb.stop  = pos_q;
			end
			n_pos  = '0;
			n_wo   = 1'b0;
			n_wb   = '0;
			n_inq  = 1'b0;
			n_qd   = 1'b0;
			n_held = HELD_NONE;
			n_hp   = '0;
		end else if (pos_q < POS_W'(MAX_LINE)) begin
			n_pos = pos_q + POS_W'(1);
			if (held_q != HELD_NONE) begin
				n_held   = HELD_NONE;
				va       = 1'b1;
				ta.start = hp_q;
				if (byte_s1 == twin) begin
					ta.kind = pk;
					ta.stop = {1'b0, hp_q} + POS_W'(2);
				end else begin
					ta.kind  = hk;
					ta.stop  = {1'b0, hp_q} + POS_W'(1);
					run_take = 1'b1;
				end
			end else begin
				run_take = 1'b1;
			end

			if (run_take) begin
				if (is_quote && !inq_q) begin
					n_inq = 1'b1;
					n_qd  = (byte_s1 == CH_DQUOTE);
					if (!wo_q) begin
						n_wo = 1'b1;
						n_wb = p;
					end
				end else if (inq_q && is_quote && ((byte_s1 == CH_DQUOTE) == qd_q)) begin
					n_inq = 1'b0;
				end

				if (!is_op && !n_wo) begin
					n_wo = 1'b1;
					n_wb = p;
				end else if (is_op && n_wo && !n_inq) begin
					vb       = 1'b1;
					tb.kind  = KIND_WORD;
					tb.start = n_wb;
					tb.stop  = pos_q;
					n_wo     = 1'b0;
				end

				if (is_op && !n_inq) begin
					if (byte_s1 == CH_PIPE) begin
						vc       = 1'b1;
						tc.kind  = KIND_PIPE;
						tc.start = p;
						tc.stop  = pos_q + POS_W'(1);
					end else begin
						n_held = (byte_s1 == CH_LT) ? HELD_LT : HELD_GT;
						n_hp   = p;
					end
				end
			end
		end

		n = 2'(va) + 2'(vb) + 2'(vc);
		push.tok0 = va ? ta : (vb ? tb : tc);
		push.tok1 = (va && vb) ? tb : tc;
		push.tok0.last = (n == 2'd1);
		push.tok1.last = (n == 2'd2);
		push.cnt = step ? n : 2'd0;
	end

	sowl_tok_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_tok   (out_tok)
	);

	assign token_kind  = out_tok.kind;
	assign token_start = out_tok.start;
	assign token_end   = out_tok.stop;
	assign token_rank  = rank_q;
	assign last_of_run = out_tok.last;

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(MAX_LINE))
		else $error("line position past maximum");

	a_held_unquoted: assert property (@(posedge clk) disable iff (!arst_n)
		(held_q != HELD_NONE) |-> (!inq_q && !wo_q))
		else $error("operator held inside quotes or open word");

	a_term_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step && term_s1) |=> (pos_q == '0 && held_q == HELD_NONE && !wo_q))
		else $error("line state not cleared after terminator");

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for shell_operator_word_lexer_core: drives command-line
// bytes and terminators, predicts every token (kind, start, end, rank, last
// flag) with an in-bench lexer model and checks the token stream in order,
// under random input gaps, random output stalls and several rank settings.
// ----------------------------------------------------------------------------
module tb import sowl_pkg::*; ;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE      = 12;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_A     = 8'h61;

	typedef struct {
		kind_t              kind;
		logic [BEG_W-1:0]   start;
		logic [POS_W-1:0]   stop;
		logic [RANK_W-1:0]  rank;
		logic               last;
	} token_rec_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [7:0]         char_byte = 8'h00;
	logic               is_terminator = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [2:0]         token_kind;
	logic [BEG_W-1:0]   token_start;
	logic [POS_W-1:0]   token_end;
	logic [RANK_W-1:0]  token_rank;
	logic               last_of_run;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [RANK_W-1:0]  line_rank = '0;

	// lexer model state
	logic [POS_W-1:0]   lx_pos;
	bit                 lx_word_open;
	logic [BEG_W-1:0]   lx_word_begin;
	bit                 lx_in_quote;
	bit                 lx_dquote;
	held_t              lx_held;
	logic [BEG_W-1:0]   lx_held_pos;
	logic [RANK_W-1:0]  lx_rank;

	token_rec_t         beat_tokens[$];
	token_rec_t         tokens_due[$];
	token_rec_t         due;
	logic [7:0]         line_buf[$];

	int                 idle_odds = 0;
	int                 stall_left = 0;
	int                 cycle_cnt = 0;
	int                 mismatches = 0;
	int                 tokens_seen = 0;
	int                 beats_sent = 0;
	int                 lines_sent = 0;
	int                 rank_writes = 0;

	shell_operator_word_lexer_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.char_byte     (char_byte),
		.is_terminator (is_terminator),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.token_kind    (token_kind),
		.token_start   (token_start),
		.token_end     (token_end),
		.token_rank    (token_rank),
		.last_of_run   (last_of_run),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.line_rank     (line_rank)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// lexer model
	// ------------------------------------------------------------------
	function automatic void clear_line();
		lx_pos        = '0;
		lx_word_open  = 1'b0;
		lx_word_begin = '0;
		lx_in_quote   = 1'b0;
		lx_dquote     = 1'b0;
		lx_held       = HELD_NONE;
		lx_held_pos   = '0;
	endfunction

	function automatic void queue_token(kind_t k, logic [BEG_W-1:0] s, logic [POS_W-1:0] e);
		token_rec_t t;
		t.kind  = k;
		t.start = s;
		t.stop  = e;
		t.rank  = lx_rank;
		t.last  = 1'b0;
		beat_tokens.push_back(t);
	endfunction

	function automatic void scan_byte(logic [7:0] c, logic [BEG_W-1:0] p);
		bit is_quote;
		bit is_op;
		is_quote = (c == CH_SQUOTE) || (c == CH_DQUOTE);
		is_op    = (c == CH_PIPE) || (c == CH_LT) || (c == CH_GT);
		if (is_quote && !lx_in_quote) begin
			lx_in_quote = 1'b1;
			lx_dquote   = (c == CH_DQUOTE);
			if (!lx_word_open) begin
				lx_word_open  = 1'b1;
				lx_word_begin = p;
			end
		end else if (lx_in_quote && is_quote && ((c == CH_DQUOTE) == lx_dquote)) begin
			lx_in_quote = 1'b0;
		end
		if (!is_op && !lx_word_open) begin
			lx_word_open  = 1'b1;
			lx_word_begin = p;
		end else if (is_op && lx_word_open && !lx_in_quote) begin
			queue_token(KIND_WORD, lx_word_begin, {1'b0, p});
			lx_word_open = 1'b0;
		end
		if (is_op && !lx_in_quote) begin
			if (c == CH_PIPE) begin
				queue_token(KIND_PIPE, p, {1'b0, p} + 11'd1);
			end else begin
				lx_held     = (c == CH_LT) ? HELD_LT : HELD_GT;
				lx_held_pos = p;
			end
		end
	endfunction

	function automatic void lex_beat(logic [7:0] c, bit term);
		logic [BEG_W-1:0] p;
		logic [7:0]       twin;
		held_t            h;
		beat_tokens.delete();
		if (term) begin
			if (lx_held != HELD_NONE)
				queue_token((lx_held == HELD_LT) ? KIND_IN_REDIR : KIND_OUT_REDIR,
					lx_held_pos, {1'b0, lx_held_pos} + 11'd1);
			if (lx_word_open && !lx_in_quote)
				queue_token(KIND_WORD, lx_word_begin, lx_pos);
			clear_line();
		end else if (lx_pos < MAX_LINE) begin
			p      = lx_pos[BEG_W-1:0];
			lx_pos = lx_pos + 11'd1;
			if (lx_held != HELD_NONE) begin
				h       = lx_held;
				twin    = (h == HELD_LT) ? CH_LT : CH_GT;
				lx_held = HELD_NONE;
				if (c == twin) begin
					queue_token((h == HELD_LT) ? KIND_HEREDOC : KIND_APPEND,
						lx_held_pos, {1'b0, lx_held_pos} + 11'd2);
				end else begin
					queue_token((h == HELD_LT) ? KIND_IN_REDIR : KIND_OUT_REDIR,
						lx_held_pos, {1'b0, lx_held_pos} + 11'd1);
					scan_byte(c, p);
				end
			end else begin
				scan_byte(c, p);
			end
		end
		if (beat_tokens.size() != 0)
			beat_tokens[beat_tokens.size()-1].last = 1'b1;
		foreach (beat_tokens[i])
			tokens_due.push_back(beat_tokens[i]);
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	task automatic send_beat(input logic [7:0] c, input bit term);
		int gap;
		gap = 0;
		if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0)
			gap = $urandom_range(1, 18);
		if (gap != 0) begin
			in_valid      <= 1'b0;
			char_byte     <= 8'($urandom);
			is_terminator <= 1'($urandom);
			repeat (gap) @(negedge clk);
		end
		in_valid      <= 1'b1;
		char_byte     <= c;
		is_terminator <= term;
		do @(posedge clk); while (in_stall);
		lex_beat(c, term);
		beats_sent++;
		if (term)
			lines_sent++;
		@(negedge clk);
	endtask

	task automatic send_term();
		send_beat(8'($urandom), 1'b1);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_beat(s[i], 1'b0);
		send_term();
	endtask

	task automatic send_buf();
		foreach (line_buf[i])
			send_beat(line_buf[i], 1'b0);
		send_term();
	endtask

	task automatic send_run(input logic [7:0] c, input int n);
		repeat (n) send_beat(c, 1'b0);
	endtask

	// hold the sender until every token is back, then let the pipe empty
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (tokens_due.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_rank(input logic [RANK_W-1:0] r);
		drain();
		cfg_valid <= 1'b1;
		line_rank <= r;
		do @(posedge clk); while (!cfg_ready);
		lx_rank = r;
		rank_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
		line_rank <= 16'($urandom);
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 11))
			0:       return 8'($urandom);
			1:       return CH_PIPE;
			2:       return CH_LT;
			3:       return CH_GT;
			4:       return CH_SQUOTE;
			5:       return CH_DQUOTE;
			6, 7:    return CH_SPACE;
			default: return CH_A + 8'($urandom_range(0, 25));
		endcase
	endfunction

	function automatic logic [7:0] pick_text();
		return ($urandom_range(0, 4) == 0) ? CH_SPACE : CH_A + 8'($urandom_range(0, 25));
	endfunction

	// command-shaped line: words, mostly matched quotes, single and doubled operators
	function automatic void build_command();
		logic [7:0] q;
		int         nseg;
		line_buf.delete();
		nseg = $urandom_range(1, 4);
		for (int s = 0; s < nseg; s++) begin
			repeat ($urandom_range(0, 4)) line_buf.push_back(pick_text());
			if ($urandom_range(0, 2) == 0) begin
				q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
				line_buf.push_back(q);
				repeat ($urandom_range(0, 4)) line_buf.push_back(pick_byte());
				if ($urandom_range(0, 7) != 0)
					line_buf.push_back(q);
			end
			if (s != nseg - 1 || $urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 5))
					0:       line_buf.push_back(CH_PIPE);
					1:       line_buf.push_back(CH_LT);
					2:       line_buf.push_back(CH_GT);
					3: begin
						line_buf.push_back(CH_LT);
						line_buf.push_back(CH_LT);
					end
					4: begin
						line_buf.push_back(CH_GT);
						line_buf.push_back(CH_GT);
					end
					default: begin
						line_buf.push_back(CH_PIPE);
						line_buf.push_back(CH_PIPE);
					end
				endcase
			end
		end
	endfunction

	function automatic void build_noise();
		line_buf.delete();
		repeat ($urandom_range(0, 12)) line_buf.push_back(
			$urandom_range(0, 1) ? 8'($urandom) : pick_byte());
	endfunction

	// ------------------------------------------------------------------
	// receiver: random stall bursts
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
			stall_left = $urandom_range(1, 18) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// token checker and watchdog
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			tokens_seen++;
			if (tokens_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0d: unexpected token kind %0d start %0d end %0d rank %0d last %0d",
						cycle_cnt, token_kind, token_start, token_end, token_rank,
						last_of_run);
			end else begin
				due = tokens_due.pop_front();
				if (token_kind !== due.kind || token_start !== due.start ||
						token_end !== due.stop || token_rank !== due.rank ||
						last_of_run !== due.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"%0d: token mismatch: expected kind %0d start %0d end %0d",
							" rank %0d last %0d, got kind %0d start %0d end %0d rank %0d last %0d"},
							cycle_cnt, due.kind, due.start, due.stop, due.rank, due.last,
							token_kind, token_start, token_end, token_rank, last_of_run);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d tokens outstanding", cycle_cnt,
				tokens_due.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_operators();
		write_rank(16'hFFFF);
		idle_odds = 6;
		send_text("a|b<c>d");
		send_text("<<x>>");
		send_text("||");
		send_text("w>");
		send_text(">'q");
	endtask

	task automatic test_quotes_and_bytes();
		write_rank(16'h0000);
		send_text("'a|\"'|\"x");
		send_text("\"<'>\" >");
		send_beat(8'h00, 1'b0);
		send_beat(8'hFF, 1'b0);
		send_term();
		send_term();
	endtask

	task automatic test_long_lines();
		write_rank(16'h8000);
		idle_odds = 60;
		send_run(CH_A, MAX_LINE - 1);
		send_beat(CH_GT, 1'b0);
		send_beat(CH_GT, 1'b0);
		send_beat(CH_A, 1'b0);
		send_term();
	endtask

	task automatic test_random_lines();
		int goal;
		int calm_from;
		goal      = beats_sent + 200;
		calm_from = goal - 60;
		write_rank(16'($urandom));
		idle_odds = 8;
		while (beats_sent < goal) begin
			if (beats_sent >= calm_from)
				idle_odds = 0;
			if ($urandom_range(0, 5) == 0)
				build_noise();
			else
				build_command();
			send_buf();
			case ($urandom_range(0, 39))
				0:       write_rank(16'($urandom));
				1:       write_rank(16'h0001);
				2:       drain();
				default: ;
			endcase
		end
	endtask

	initial begin
		lx_rank = '0;
		clear_line();
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_operators();
		test_quotes_and_bytes();
		test_long_lines();
		test_random_lines();
		in_valid <= 1'b0;
		idle_odds = 0;
		@(negedge clk);
		while (tokens_due.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		$display("lexed %0d lines in %0d byte beats, %0d tokens checked, %0d rank settings",
			lines_sent, beats_sent, tokens_seen, rank_writes);
		$display("mismatches %0d, tokens never delivered %0d", mismatches, tokens_due.size());
		if (mismatches == 0 && tokens_due.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
